// ===== rtl/idda_pkg.sv =====
// Package for the identifier allocator: field widths, operation and status
// codes, FSM states, and the command and status bundles between the controller
// and the datapath. No dependencies.
`default_nettype none

package idda_pkg;

  localparam int unsigned NUM_IDS_DEF    = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned FLOOR_W  = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = FUNC_W;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = STATUS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_FIND       = 3'd1,
    FN_REPLACE    = 3'd2,
    FN_REMOVE     = 3'd3,
    FN_REMOVE_ALL = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    latch;
    logic    scan_start;
    logic    scan_next;
    logic    alloc_commit;
    logic    mem_rd;
    logic    mem_wr_replace;
    logic    rm_one;
    logic    rm_all;
    logic    res_set;
    status_e res_status;
    logic    res_alloc;
    logic    res_rdata;
    logic    out_load;
  } idda_cmd_t;

  typedef struct packed {
    func_e func;
    logic  in_use;
    logic  start_oob;
    logic  hit;
    logic  scan_end;
    logic  out_free;
  } idda_stat_t;

endpackage

`default_nettype wire

// ===== rtl/idda_ctrl.sv =====
// Controller state machine of the identifier allocator.
// Depends on idda_pkg; drives idda_dpath through command and status bundles.
`default_nettype none

module idda_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire idda_pkg::idda_stat_t stat_i,
  output idda_pkg::idda_cmd_t       cmd_o
);
  import idda_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_status = ST_OK;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.func)
          FN_ALLOC: begin
            if (stat_i.start_oob) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_FULL;
              state_d          = S_RESP;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          FN_FIND, FN_REPLACE: begin
            if (stat_i.in_use) begin
              cmd_o.mem_rd = 1'b1;
              state_d      = S_READ;
            end else begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_NOT_USED;
              state_d          = S_RESP;
            end
          end
          FN_REMOVE: begin
            cmd_o.rm_one     = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = stat_i.in_use ? ST_OK : ST_NOT_USED;
            state_d          = S_RESP;
          end
          FN_REMOVE_ALL: begin
            cmd_o.rm_all  = 1'b1;
            cmd_o.res_set = 1'b1;
            state_d       = S_RESP;
          end
          default: begin
            cmd_o.res_set = 1'b1;
            state_d       = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.alloc_commit = 1'b1;
          cmd_o.res_set      = 1'b1;
          cmd_o.res_alloc    = 1'b1;
          state_d            = S_RESP;
        end else if (stat_i.scan_end) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.res_set        = 1'b1;
        cmd_o.res_rdata      = 1'b1;
        cmd_o.mem_wr_replace = (stat_i.func == FN_REPLACE);
        state_d              = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_commit_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc_commit |-> stat_i.hit && stat_i.func == FN_ALLOC)
    else $error("allocate committed without a free identifier");
  a_read_needs_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_rd |-> stat_i.in_use)
    else $error("data store read for an identifier not in use");
  a_scan_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_SCAN) |-> $past(state_q == S_EXEC && stat_i.func == FN_ALLOC))
    else $error("scan entered outside of allocate");
`endif

endmodule

`default_nettype wire

// ===== rtl/idda_dpath.sv =====
// Datapath of the identifier allocator: used map, low-water hint, chunked
// free-identifier scan, data store memory and the result and output registers.
// Depends on idda_pkg; controlled by idda_ctrl.
`default_nettype none

module idda_dpath #(
  parameter int unsigned NUM_IDS    = idda_pkg::NUM_IDS_DEF,
  parameter int unsigned DATA_WIDTH = idda_pkg::DATA_WIDTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire idda_pkg::idda_cmd_t           cmd_i,
  output idda_pkg::idda_stat_t               stat_o,
  input  wire [idda_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  wire [idda_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [idda_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic [idda_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
  import idda_pkg::*;

  localparam int unsigned IdW    = $clog2(NUM_IDS);
  localparam int unsigned PadN   = 1 << IdW;
  localparam int unsigned ChunkW = (PadN < 32) ? PadN : 32;
  localparam int unsigned BitW   = $clog2(ChunkW);
  localparam int unsigned LwW    = IdW + 1;
  localparam int unsigned CmpW   = (LwW > 9) ? LwW : 9;

  func_e                 func_q;
  logic [ID_W-1:0]       id_q;
  logic [FLOOR_W-1:0]    floor_q;
  logic [WORD_W-1:0]     word_q;

  logic [NUM_IDS-1:0]    used_q;
  logic [PadN-1:0]       used_pad;
  logic [LwW-1:0]        lw_q;
  logic [IdW-1:0]        sp_q;

  logic [DATA_WIDTH-1:0] mem_q [NUM_IDS];
  logic [DATA_WIDTH-1:0] rd_q;

  status_e               res_status_q;
  logic [ID_W-1:0]       res_id_q;
  logic [WORD_W-1:0]     res_data_q;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [ID_W-1:0]       out_id_q;
  logic [WORD_W-1:0]     out_data_q;

  logic [CmpW-1:0]       id_x, floor_x, lw_x, n_x, start_x;
  logic [IdW-1:0]        id_idx;
  logic                  id_in_range;
  logic                  in_use;
  logic [IdW-1:0]        base;
  logic [ChunkW-1:0]     chunk, ones, free_v;
  logic [BitW-1:0]       off, hit_idx;
  logic [IdW-1:0]        cand;
  logic [IdW:0]          nxt;
  logic                  out_free;
  logic                  mem_wr;
  logic [IdW-1:0]        mem_wa;
  logic [DATA_WIDTH-1:0] word_ext;

  always_comb begin
    used_pad              = '1;
    used_pad[NUM_IDS-1:0] = used_q;
  end

  assign id_x        = CmpW'(id_q);
  assign floor_x     = CmpW'(floor_q);
  assign lw_x        = CmpW'(lw_q);
  assign n_x         = CmpW'(NUM_IDS);
  assign start_x     = (floor_x < lw_x) ? lw_x : floor_x;
  assign id_idx      = IdW'(id_q);
  assign id_in_range = id_x < n_x;
  assign in_use      = id_in_range && used_pad[id_idx];
  assign word_ext    = DATA_WIDTH'(word_q);

  // One group of identifiers is examined per cycle, starting at the scan pointer.
  assign base   = sp_q & ~IdW'(ChunkW - 1);
  assign chunk  = used_pad[base +: ChunkW];
  assign off    = sp_q[BitW-1:0];
  assign ones   = '1;
  assign free_v = ~chunk & (ones << off);

  always_comb begin
    hit_idx = '0;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        hit_idx = BitW'(i);
      end
    end
  end

  assign cand     = base | IdW'(hit_idx);
  assign nxt      = {1'b0, base} + (IdW + 1)'(ChunkW);
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    stat_o           = '0;
    stat_o.func      = func_q;
    stat_o.in_use    = in_use;
    stat_o.start_oob = start_x >= n_x;
    stat_o.hit       = |free_v;
    stat_o.scan_end  = nxt[IdW];
    stat_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_e'(s_axis_tuser);
      id_q    <= s_axis_tdata[ID_W-1:0];
      floor_q <= s_axis_tdata[ID_W +: FLOOR_W];
      word_q  <= s_axis_tdata[ID_W + FLOOR_W +: WORD_W];
    end
    if (cmd_i.scan_start) begin
      sp_q <= IdW'(start_x);
    end else if (cmd_i.scan_next) begin
      sp_q <= nxt[IdW-1:0];
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_id_q     <= cmd_i.res_alloc ? ID_W'(cand) : id_q;
      res_data_q   <= cmd_i.res_rdata ? WORD_W'(rd_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_data_q   <= res_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      lw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rm_all) begin
        used_q <= '0;
        lw_q   <= '0;
      end else if (cmd_i.rm_one) begin
        if (in_use) begin
          used_q[id_idx] <= 1'b0;
        end
        if (id_x < lw_x) begin
          lw_q <= LwW'(id_x);
        end
      end else if (cmd_i.alloc_commit) begin
        used_q[cand] <= 1'b1;
        if (floor_x <= lw_x) begin
          lw_q <= LwW'(cand) + LwW'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign mem_wr = cmd_i.alloc_commit || cmd_i.mem_wr_replace;
  assign mem_wa = cmd_i.alloc_commit ? cand : id_idx;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[mem_wa] <= word_ext;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[id_idx];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_data_q, out_id_q};

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result overwrote an item not yet taken");
  a_lw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_x <= n_x)
    else $error("low-water hint beyond the identifier range");
  a_commit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |=> used_pad[$past(cand)])
    else $error("allocated identifier not marked used");
  a_hint_below_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_start |-> !(floor_x <= lw_x && lw_x != CmpW'(0) && !used_pad[IdW'(lw_x - 1)]))
    else $error("identifier below the low-water hint is free");
`endif

endmodule

`default_nettype wire

// ===== rtl/id_to_data_allocator.sv =====
// Channel   | Dir | tdata (low bit up)             | tuser
// s_axis    | in  | id[7:0] floor[15:8] data[47:16] | func[2:0]
// m_axis    | out | result_id[7:0] result_data[39:8] | status[1:0]
//
// One item at a time. Find and replace of an identifier in use pass through the
// execute, read and response states; other codes go from execute to response.
// Allocate visits groups of up to 32 identifiers in the scan state.
// Reset clears the used map and the low-water hint at once; the data store is
// not cleared. A new item is accepted while the previous result waits in the
// output register; a stalled output holds the block in its last state.
// Depends on idda_pkg, idda_ctrl and idda_dpath.
`default_nettype none

module id_to_data_allocator #(
  parameter int unsigned NUM_IDS    = idda_pkg::NUM_IDS_DEF,
  parameter int unsigned DATA_WIDTH = idda_pkg::DATA_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [idda_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // id, floor, data
  input  wire [idda_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [idda_pkg::M_TDATA_W-1:0] m_axis_tdata,  // result_id, result_data
  output logic [idda_pkg::M_TUSER_W-1:0] m_axis_tuser   // status
);
  import idda_pkg::*;

  idda_cmd_t  cmd;
  idda_stat_t stat;

  idda_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  idda_dpath #(
    .NUM_IDS    (NUM_IDS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== sim/tb_id_to_data_allocator.sv =====
// Self-checking testbench for id_to_data_allocator: directed, fill-to-full and random
// allocate, find, replace and remove traffic, checked against an in-bench predictor.
// Depends on idda_pkg and the id_to_data_allocator RTL.
module tb_id_to_data_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import idda_pkg::*;

  localparam int unsigned NUM_IDS = NUM_IDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST = 3'd7;

  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   rid;
    logic [WORD_W-1:0] rdata;
  } reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  logic [NUM_IDS-1:0] id_used = '0;
  logic [WORD_W-1:0]  id_word [NUM_IDS];
  logic [8:0]         free_hint = '0;
  reply_t             pending_replies [$];
  bit                 idle_on = 1'b1;
  int unsigned        mismatches = 0;
  int unsigned        cycle_cnt = 0;

  id_to_data_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic reply_t compute_reply(input logic [FUNC_W-1:0] fn,
                                           input logic [ID_W-1:0] id,
                                           input logic [FLOOR_W-1:0] flr,
                                           input logic [WORD_W-1:0] word);
    reply_t      r;
    int unsigned cand;
    r.status = ST_OK;
    r.rid    = id;
    r.rdata  = '0;
    case (fn)
      FN_ALLOC: begin
        cand = (flr < free_hint) ? int'(free_hint) : int'(flr);
        while (cand < NUM_IDS && id_used[cand]) cand++;
        if (cand >= NUM_IDS) begin
          r.status = ST_FULL;
        end else begin
          id_used[cand] = 1'b1;
          id_word[cand] = word;
          r.rid = 8'(cand);
          if (flr <= free_hint) free_hint = 9'(cand + 1);
        end
      end
      FN_FIND: begin
        if (id_used[id]) r.rdata = id_word[id];
        else r.status = ST_NOT_USED;
      end
      FN_REPLACE: begin
        if (id_used[id]) begin
          r.rdata = id_word[id];
          id_word[id] = word;
        end else begin
          r.status = ST_NOT_USED;
        end
      end
      FN_REMOVE: begin
        if (id_used[id]) id_used[id] = 1'b0;
        else r.status = ST_NOT_USED;
        if (id < free_hint) free_hint = {1'b0, id};
      end
      FN_REMOVE_ALL: begin
        id_used = '0;
        free_hint = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                           input logic [FLOOR_W-1:0] flr, input logic [WORD_W-1:0] word);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {word, flr, id};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(compute_reply(fn, id, flr, word));
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
                                 input logic [WORD_W-1:0] act_v);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
    mismatches++;
  endtask

  initial begin
    int unsigned stall;
    reply_t      exp_r;
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_replies.size() == 0) begin
        $display("%0t: result with no item outstanding, actual status %0d id %0d data 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8]);
        mismatches++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (m_axis_tuser !== exp_r.status)
          report_mismatch("status", 32'(exp_r.status), 32'(m_axis_tuser));
        if (m_axis_tdata[7:0] !== exp_r.rid)
          report_mismatch("result_id", 32'(exp_r.rid), 32'(m_axis_tdata[7:0]));
        if (m_axis_tdata[39:8] !== exp_r.rdata)
          report_mismatch("result_data", exp_r.rdata, m_axis_tdata[39:8]);
      end
    end
  end

  task automatic test_directed();
    send_item(FN_FIND, 8'd0, 8'd0, 32'h0);
    send_item(FN_REPLACE, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_item(FN_REMOVE, 8'd0, 8'd0, 32'h0);
    send_item(FN_REMOVE, 8'd255, 8'd0, 32'h0);
    send_item(FN_ALLOC, 8'd255, 8'd0, 32'h0);
    send_item(FN_ALLOC, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_item(FN_ALLOC, 8'd0, 8'd255, 32'hA5A5_A5A5);
    send_item(FN_ALLOC, 8'd17, 8'd255, 32'h1111_1111);
    send_item(FN_FIND, 8'd255, 8'd0, 32'h0);
    send_item(FN_FIND, 8'd1, 8'd0, 32'h0);
    send_item(FN_FIND, 8'd0, 8'd0, 32'h0);
    send_item(FN_REPLACE, 8'd1, 8'd0, 32'h5A5A_5A5A);
    send_item(FN_FIND, 8'd1, 8'd0, 32'h0);
    send_item(FN_REMOVE, 8'd0, 8'd0, 32'h0);
    send_item(FN_REMOVE, 8'd0, 8'd0, 32'h0);
    send_item(FN_ALLOC, 8'd0, 8'd0, 32'hDEAD_BEEF);
    send_item(FN_ALLOC, 8'd0, 8'd128, 32'h1234_5678);
    send_item(FN_ALLOC, 8'd0, 8'd0, 32'h8765_4321);
    send_item(FN_SPARE_FIRST, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_item(FN_SPARE_FIRST + 3'd1, 8'd1, 8'd0, 32'h0);
    send_item(FN_SPARE_LAST, 8'd128, 8'd255, 32'hFFFF_FFFF);
    send_item(FN_REMOVE_ALL, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_item(FN_FIND, 8'd1, 8'd0, 32'h0);
    send_item(FN_ALLOC, 8'd0, 8'd0, 32'hCAFE_F00D);
  endtask

  task automatic test_fill_to_full();
    idle_on = 1'b0;
    send_item(FN_REMOVE_ALL, 8'($urandom), 8'($urandom), $urandom);
    for (int i = 0; i < NUM_IDS; i++) begin
      if (i == NUM_IDS / 2) idle_on = 1'b1;
      send_item(FN_ALLOC, 8'($urandom), 8'd0, $urandom);
    end
    send_item(FN_ALLOC, 8'($urandom), 8'd0, $urandom);
    send_item(FN_ALLOC, 8'($urandom), 8'($urandom), $urandom);
    for (int i = 0; i < 10; i++) send_item(FN_REMOVE, 8'($urandom), 8'd0, $urandom);
    for (int i = 0; i < 12; i++) send_item(FN_ALLOC, 8'($urandom), 8'($urandom), $urandom);
    send_item(FN_REMOVE_ALL, 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned alloc_pct);
    logic [FUNC_W-1:0]  fn;
    logic [ID_W-1:0]    id;
    logic [ID_W-1:0]    start;
    logic [FLOOR_W-1:0] flr;
    int unsigned        pick;
    for (int n = 0; n < count; n++) begin
      idle_on = (n % 100) >= 20;
      start = 8'($urandom_range(0, 255));
      id = start;
      if ($urandom_range(0, 4) != 0) begin
        for (int k = 0; k < NUM_IDS; k++) begin
          if (id_used[8'(start + k)]) begin
            id = 8'(start + k);
            break;
          end
        end
      end
      case ($urandom_range(0, 3))
        0: flr = 8'd0;
        1: flr = 8'($urandom_range(0, 15));
        2: flr = 8'($urandom);
        default: flr = 8'd255;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        fn = FN_ALLOC;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) fn = FN_FIND;
        else if (pick < 50) fn = FN_REPLACE;
        else if (pick < 92) fn = FN_REMOVE;
        else if (pick < 97) fn = 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        else fn = FN_REMOVE_ALL;
      end
      send_item(fn, id, flr, $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_to_full();
    test_random_mix(250, 35);
    test_random_mix(150, 80);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
